// ----- design/stq_pkg.sv -----
// shared types and constants of the spi transaction queue sequencer
package stq_pkg;

	// most words one request word may cause
	localparam int MaxResults = 18;

	// request codes
	typedef enum logic [2:0] {
		REQ_SUBMIT        = 3'd0,
		REQ_MARKER        = 3'd1,
		REQ_HALF          = 3'd2,
		REQ_COMPLETE      = 3'd3,
		REQ_BUS_ERROR     = 3'd4,
		REQ_CANCEL        = 3'd5,
		REQ_START_REFUSED = 3'd6
	} req_kind_t;

	// result event codes
	typedef enum logic [2:0] {
		EV_OK        = 3'd0,
		EV_PARAM     = 3'd1,
		EV_FULL      = 3'd2,
		EV_START     = 3'd3,
		EV_HALF      = 3'd4,
		EV_DONE      = 3'd5,
		EV_ERROR     = 3'd6,
		EV_MARKER    = 3'd7
	} event_kind_t;

	// dc_mode codes
	localparam logic [1:0] DcCommand = 2'd1;
	localparam logic [1:0] DcIllegal = 2'd3;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FETCH,
		ST_START
	} seq_state_t;

	// request word
	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] tag;
		logic        dir;
		logic [1:0]  dc_mode;
		logic [3:0]  cs_id;
		logic [31:0] tx_addr;
		logic [31:0] rx_addr;
		logic [15:0] length;
		logic [31:0] ctrl_one;
		logic [31:0] ctrl_two;
		logic        wait_ok;
	} req_t;

	// result word
	typedef struct packed {
		event_kind_t event_kind;
		logic [15:0] out_tag;
		logic        out_dir;
		logic [1:0]  out_dc_mode;
		logic [3:0]  out_cs_id;
		logic [31:0] out_tx_addr;
		logic [31:0] out_rx_addr;
		logic [15:0] out_length;
		logic [31:0] out_ctrl_one;
		logic [31:0] out_ctrl_two;
		logic        idle;
		logic        last;
	} rsp_t;

	// one queue entry as stored in the descriptor ram
	typedef struct packed {
		logic [31:0] tx_addr;
		logic [31:0] rx_addr;
		logic [31:0] ctrl_one;
		logic [31:0] ctrl_two;
		logic [15:0] length;
		logic [15:0] tag;
		logic [3:0]  cs_id;
		logic [1:0]  dc_mode;
		logic        dir;
		logic        marker;
	} entry_t;

endpackage

// ----- design/stq_req_if.sv -----
// request channel interface
interface stq_req_if;
	logic          valid;
	logic          ready;
	stq_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/stq_rsp_if.sv -----
// result channel interface
interface stq_rsp_if;
	logic          valid;
	logic          ready;
	stq_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/stq_entry_ram.sv -----
// descriptor ram: one write port, one read port with registered data
module stq_entry_ram #(
	parameter int Depth = 16,
	parameter int AddrW = 4
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AddrW-1:0]     waddr,
	input  stq_pkg::entry_t      wdata,
	input  logic [AddrW-1:0]     raddr,
	output stq_pkg::entry_t      rdata
);

	stq_pkg::entry_t mem [Depth];
	stq_pkg::entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/spi_transaction_queue_sequencer.sv -----
// SPI transfer descriptor queue and start sequencer. Request words submit transfers or markers
// and report bus events; result words carry status, start commands and notifications. A request
// word is taken only in the idle state and goes through accept, execute, head fetch and start
// check, plus a head fetch and start check for each marker that retires, since every look at
// the head waits on the registered read of the descriptor ram. A result word that is not
// taken stalls the sequencer in place. QUEUE_DEPTH slots hold at most QUEUE_DEPTH-1 entries.
module spi_transaction_queue_sequencer #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	stq_req_if.sink   req,
	stq_rsp_if.source rsp
);

	localparam int IdxW = $clog2(QUEUE_DEPTH);

	stq_pkg::seq_state_t state_q, state_d;
	logic [IdxW-1:0]     head_q, head_d;
	logic [IdxW-1:0]     tail_q, tail_d;
	logic                busy_q, busy_d;
	logic [4:0]          cnt_q, cnt_d;
	stq_pkg::req_t       req_q;
	logic                out_valid_q;
	stq_pkg::rsp_t       out_q;
	stq_pkg::rsp_t       word;
	logic                load;
	logic                can_load;
	logic                we;
	stq_pkg::entry_t     wdata;
	stq_pkg::entry_t     rd_entry;
	logic                accept;

	function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] i);
		if (i == IdxW'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return i + 1'b1;
	endfunction

	stq_entry_ram #(
		.Depth (QUEUE_DEPTH),
		.AddrW (IdxW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (tail_q),
		.wdata (wdata),
		.raddr (head_q),
		.rdata (rd_entry)
	);

	assign req.ready = (state_q == stq_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign can_load  = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// sequencer next state, queue updates and result word
	always_comb begin
		logic                 want;
		logic                 bad;
		logic                 ok;
		logic [IdxW-1:0]      nh;
		logic [IdxW-1:0]      nt;
		logic                 nb;
		logic                 full;
		logic                 empty;
		logic [1:0]           dc;
		stq_pkg::event_kind_t kind;

		state_d = state_q;
		head_d  = head_q;
		tail_d  = tail_q;
		busy_d  = busy_q;
		cnt_d   = cnt_q;
		load    = 1'b0;
		we      = 1'b0;
		word    = '0;
		want    = 1'b0;
		bad     = 1'b0;
		ok      = 1'b0;
		nh      = head_q;
		nt      = tail_q;
		nb      = busy_q;
		kind    = stq_pkg::EV_OK;
		empty   = (head_q == tail_q);
		full    = (next_slot(tail_q) == head_q);
		dc      = (req_q.dc_mode == stq_pkg::DcIllegal) ? stq_pkg::DcCommand : req_q.dc_mode;

		// entry built from the latched request
		wdata          = '0;
		wdata.tag      = req_q.tag;
		if (req_q.req_type == stq_pkg::REQ_MARKER) begin
			wdata.marker = 1'b1;
		end else begin
			wdata.tx_addr  = req_q.tx_addr;
			wdata.rx_addr  = req_q.rx_addr;
			wdata.ctrl_one = req_q.ctrl_one;
			wdata.ctrl_two = req_q.ctrl_two;
			wdata.length   = req_q.length;
			wdata.cs_id    = req_q.cs_id;
			wdata.dc_mode  = dc;
			wdata.dir      = req_q.dir;
		end

		case (state_q)
			stq_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = stq_pkg::ST_EXEC;
				end
			end
			stq_pkg::ST_EXEC: begin
				case (req_q.req_type)
					stq_pkg::REQ_SUBMIT, stq_pkg::REQ_MARKER: begin
						if (req_q.req_type == stq_pkg::REQ_SUBMIT) begin
							bad = (req_q.cs_id == '0) || (req_q.tx_addr == '0) ||
								(req_q.length == '0) || (req_q.dir && req_q.rx_addr == '0);
						end
						ok   = !bad && !full;
						kind = bad ? stq_pkg::EV_PARAM : (full ? stq_pkg::EV_FULL : stq_pkg::EV_OK);
						nt   = ok ? next_slot(tail_q) : tail_q;
						want = 1'b1;
						word.event_kind = kind;
						word.out_tag    = req_q.tag;
						word.idle       = !busy_q && (head_q == nt);
						word.last       = !(!busy_q && (head_q != nt));
					end
					stq_pkg::REQ_HALF: begin
						if (busy_q && !empty) begin
							want = 1'b1;
							word.event_kind = stq_pkg::EV_HALF;
							word.out_tag    = rd_entry.tag;
							word.out_cs_id  = rd_entry.cs_id;
							word.idle       = 1'b0;
							word.last       = 1'b1;
						end
					end
					stq_pkg::REQ_COMPLETE, stq_pkg::REQ_BUS_ERROR,
					stq_pkg::REQ_START_REFUSED: begin
						if (busy_q && !empty) begin
							want = 1'b1;
							nh   = next_slot(head_q);
							nb   = 1'b0;
							word.event_kind = (req_q.req_type == stq_pkg::REQ_COMPLETE &&
								req_q.wait_ok) ? stq_pkg::EV_DONE : stq_pkg::EV_ERROR;
							word.out_tag    = rd_entry.tag;
							word.out_cs_id  = rd_entry.cs_id;
							word.idle       = (nh == tail_q);
							word.last       = (nh == tail_q);
						end
					end
					stq_pkg::REQ_CANCEL: begin
						nt = (busy_q && !empty) ? next_slot(head_q) : head_q;
					end
					default: begin
					end
				endcase
				if (!want || can_load) begin
					load    = want;
					we      = ok;
					head_d  = nh;
					tail_d  = nt;
					busy_d  = nb;
					cnt_d   = want ? 5'd1 : 5'd0;
					state_d = stq_pkg::ST_FETCH;
				end
			end
			stq_pkg::ST_FETCH: begin
				state_d = stq_pkg::ST_START;
			end
			stq_pkg::ST_START: begin
				if (!busy_q && !empty && cnt_q < 5'(stq_pkg::MaxResults)) begin
					if (can_load) begin
						load = 1'b1;
						word.out_tag = rd_entry.tag;
						if (rd_entry.marker) begin
							// marker retires at once, then look at the next head
							nh = next_slot(head_q);
							word.event_kind = stq_pkg::EV_MARKER;
							word.idle       = (nh == tail_q);
							word.last       = !((nh != tail_q) &&
								(cnt_q + 5'd1 < 5'(stq_pkg::MaxResults)));
							head_d  = nh;
							cnt_d   = cnt_q + 5'd1;
							state_d = stq_pkg::ST_FETCH;
						end else begin
							word.event_kind   = stq_pkg::EV_START;
							word.out_dir      = rd_entry.dir;
							word.out_dc_mode  = rd_entry.dc_mode;
							word.out_cs_id    = rd_entry.cs_id;
							word.out_tx_addr  = rd_entry.tx_addr;
							word.out_rx_addr  = rd_entry.rx_addr;
							word.out_length   = rd_entry.length;
							word.out_ctrl_one = rd_entry.ctrl_one;
							word.out_ctrl_two = rd_entry.ctrl_two;
							word.idle         = 1'b0;
							word.last         = 1'b1;
							busy_d  = 1'b1;
							state_d = stq_pkg::ST_IDLE;
						end
					end
				end else begin
					state_d = stq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stq_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stq_pkg::ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			busy_q  <= busy_d;
			cnt_q   <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result words
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.data;
		end
		if (load) begin
			out_q <= word;
		end
	end

	// a transfer in flight always sits at the head of the queue
	a_busy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> head_q != tail_q)
		else $error("busy with an empty queue");

	// per-request word count stays within the chain limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'(stq_pkg::MaxResults))
		else $error("too many words for one request");

	// a start command ends the words of its request
	a_start_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.event_kind == stq_pkg::EV_START |-> out_q.last && busy_q)
		else $error("start command not last or bus not busy");

	// the request word is taken only between requests
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == stq_pkg::ST_EXEC)
		else $error("accepted request not executed");

endmodule

// ----- tb/spi_transaction_queue_sequencer_tb.sv -----
// self-checking testbench of the spi transaction queue sequencer
module spi_transaction_queue_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RingDepth   = 16;
	localparam int          IdlePct     = 11;
	localparam int          ItemTarget  = 480;
	localparam int          DrainCycles = 64;
	localparam int          CycleLimit  = 400000;
	localparam int          ReportCap   = 100;
	localparam logic [2:0]  ReqReserved = 3'd7;

	// one row of the directed table
	typedef struct {
		stq_pkg::req_t        word;
		bit                   given;
		stq_pkg::event_kind_t kind;
	} row_t;

	logic clk;
	logic arst_n;

	stq_req_if req_ch ();
	stq_rsp_if rsp_ch ();

	spi_transaction_queue_sequencer #(
		.QUEUE_DEPTH(RingDepth)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// descriptor ring as the sequencer should hold it
	stq_pkg::entry_t      ring [RingDepth];
	int unsigned          ring_head = 0;
	int unsigned          ring_tail = 0;
	bit                   in_flight = 1'b0;

	// words still to arrive, oldest first
	stq_pkg::rsp_t        expected_words [$];
	stq_pkg::rsp_t        held_word;
	bit                   word_held;
	int                   step_words;
	bit                   first_forced;
	stq_pkg::event_kind_t first_kind;

	row_t        rows [$];
	bit          steady = 1'b0;
	int          words_sent = 0;
	int          words_checked = 0;
	int          failures = 0;
	int          kind_tally [8];
	int          cycle_count = 0;

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic int unsigned ring_next(int unsigned i);
		return (i + 1 >= RingDepth) ? 0 : i + 1;
	endfunction

	function automatic bit ring_empty();
		return ring_head == ring_tail;
	endfunction

	function automatic bit ring_full();
		return ring_next(ring_tail) == ring_head;
	endfunction

	function automatic stq_pkg::rsp_t plain_word(stq_pkg::event_kind_t k, logic [15:0] tg,
	                                             logic [3:0] cs);
		stq_pkg::rsp_t w;
		w = '0;
		w.event_kind = k;
		w.out_tag = tg;
		w.out_cs_id = cs;
		return w;
	endfunction

	// idle reflects the ring right after this word; last is set once the request is done
	function automatic void queue_word(stq_pkg::rsp_t w);
		if (step_words >= stq_pkg::MaxResults) return;
		w.idle = !in_flight && ring_empty();
		w.last = 1'b0;
		if (step_words == 0 && first_forced) w.event_kind = first_kind;
		if (word_held) expected_words.push_back(held_word);
		held_word = w;
		word_held = 1'b1;
		step_words++;
	endfunction

	// pop the transfer in flight and release its select
	function automatic void retire_head(stq_pkg::event_kind_t k);
		stq_pkg::entry_t e;
		e = ring[ring_head];
		ring_head = ring_next(ring_head);
		in_flight = 1'b0;
		queue_word(plain_word(k, e.tag, e.cs_id));
	endfunction

	// work out the words one accepted request causes
	function automatic int predict_request(stq_pkg::req_t r, bit forced,
	                                       stq_pkg::event_kind_t kind);
		stq_pkg::entry_t e;
		stq_pkg::rsp_t   w;
		bit              live;
		step_words = 0;
		word_held = 1'b0;
		first_forced = forced;
		first_kind = kind;
		live = in_flight && !ring_empty();
		e = '0;
		e.tag = r.tag;
		case (r.req_type)
			stq_pkg::REQ_SUBMIT: begin
				if (r.cs_id == 4'h0 || r.tx_addr == 32'h0 || r.length == 16'h0 ||
				    (r.dir && r.rx_addr == 32'h0)) begin
					queue_word(plain_word(stq_pkg::EV_PARAM, r.tag, 4'h0));
				end else if (ring_full()) begin
					queue_word(plain_word(stq_pkg::EV_FULL, r.tag, 4'h0));
				end else begin
					e.tx_addr = r.tx_addr;
					e.rx_addr = r.rx_addr;
					e.ctrl_one = r.ctrl_one;
					e.ctrl_two = r.ctrl_two;
					e.length = r.length;
					e.cs_id = r.cs_id;
					e.dir = r.dir;
					e.dc_mode = (r.dc_mode == stq_pkg::DcIllegal) ? stq_pkg::DcCommand :
						r.dc_mode;
					ring[ring_tail] = e;
					ring_tail = ring_next(ring_tail);
					queue_word(plain_word(stq_pkg::EV_OK, r.tag, 4'h0));
				end
			end
			stq_pkg::REQ_MARKER: begin
				if (ring_full()) begin
					queue_word(plain_word(stq_pkg::EV_FULL, r.tag, 4'h0));
				end else begin
					e.marker = 1'b1;
					ring[ring_tail] = e;
					ring_tail = ring_next(ring_tail);
					queue_word(plain_word(stq_pkg::EV_OK, r.tag, 4'h0));
				end
			end
			stq_pkg::REQ_HALF: begin
				if (live) queue_word(plain_word(stq_pkg::EV_HALF, ring[ring_head].tag,
				                                ring[ring_head].cs_id));
			end
			stq_pkg::REQ_COMPLETE: begin
				if (live) retire_head(r.wait_ok ? stq_pkg::EV_DONE : stq_pkg::EV_ERROR);
			end
			stq_pkg::REQ_BUS_ERROR, stq_pkg::REQ_START_REFUSED: begin
				if (live) retire_head(stq_pkg::EV_ERROR);
			end
			// the transfer in flight survives a cancel
			stq_pkg::REQ_CANCEL: begin
				ring_tail = live ? ring_next(ring_head) : ring_head;
			end
			default: ;
		endcase
		// markers at the head retire at once, a transfer starts
		while (!in_flight && !ring_empty() && step_words < stq_pkg::MaxResults) begin
			e = ring[ring_head];
			if (e.marker) begin
				ring_head = ring_next(ring_head);
				queue_word(plain_word(stq_pkg::EV_MARKER, e.tag, 4'h0));
			end else begin
				in_flight = 1'b1;
				w = plain_word(stq_pkg::EV_START, e.tag, e.cs_id);
				w.out_dir = e.dir;
				w.out_dc_mode = e.dc_mode;
				w.out_tx_addr = e.tx_addr;
				w.out_rx_addr = e.rx_addr;
				w.out_length = e.length;
				w.out_ctrl_one = e.ctrl_one;
				w.out_ctrl_two = e.ctrl_two;
				queue_word(w);
			end
		end
		if (word_held) begin
			held_word.last = 1'b1;
			expected_words.push_back(held_word);
		end
		return step_words;
	endfunction

	function automatic void add_row(logic [2:0] op, logic [15:0] tag, logic dir, logic [1:0] dc,
	                                logic [3:0] cs, logic [31:0] tx, logic [31:0] rx,
	                                logic [15:0] len, logic [31:0] c1, logic [31:0] c2,
	                                logic ok, bit given, stq_pkg::event_kind_t kind);
		row_t row;
		row.word.req_type = op;
		row.word.tag = tag;
		row.word.dir = dir;
		row.word.dc_mode = dc;
		row.word.cs_id = cs;
		row.word.tx_addr = tx;
		row.word.rx_addr = rx;
		row.word.length = len;
		row.word.ctrl_one = c1;
		row.word.ctrl_two = c2;
		row.word.wait_ok = ok;
		row.given = given;
		row.kind = kind;
		rows.push_back(row);
	endfunction

	// random content; shaped submits are mostly well formed
	function automatic stq_pkg::req_t random_request(logic [2:0] op, bit shaped);
		stq_pkg::req_t w;
		w.req_type = op;
		w.tag = 16'($urandom);
		w.dir = 1'($urandom);
		w.dc_mode = 2'($urandom);
		w.cs_id = 4'($urandom);
		w.tx_addr = $urandom;
		w.rx_addr = $urandom;
		w.length = 16'($urandom);
		w.ctrl_one = $urandom;
		w.ctrl_two = $urandom;
		w.wait_ok = 1'($urandom);
		if (shaped && op == stq_pkg::REQ_SUBMIT) begin
			w.cs_id = 4'($urandom_range(15, 1));
			if (w.tx_addr == 32'h0) w.tx_addr = 32'h4;
			if (w.length == 16'h0) w.length = 16'h1;
			if (w.dir && w.rx_addr == 32'h0) w.rx_addr = 32'h8;
			// one in ten breaks a single check
			case ($urandom_range(39))
				0: w.cs_id = 4'h0;
				1: w.tx_addr = 32'h0;
				2: w.length = 16'h0;
				3: begin
					w.dir = 1'b1;
					w.rx_addr = 32'h0;
				end
				default: ;
			endcase
		end
		return w;
	endfunction

	// drive one request word at the falling edge and wait for it to be taken
	task automatic send_request(stq_pkg::req_t w, bit given, stq_pkg::event_kind_t kind);
		while (!steady && $urandom_range(99) < IdlePct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		void'(predict_request(w, given, kind));
		words_sent++;
		@(negedge clk);
	endtask

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			failures++;
			if (failures <= ReportCap)
				$display("%0t ns: result word %0d, %s expected %0h actual %0h",
				         $time, words_checked, name, want, got);
		end
	endfunction

	// compare each result word taken with the oldest expectation
	always @(posedge clk) begin
		stq_pkg::rsp_t want;
		stq_pkg::rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (expected_words.size() == 0) begin
				failures++;
				$display("%0t ns: result word with none expected, kind %0d tag %0h",
				         $time, got.event_kind, got.out_tag);
			end else begin
				want = expected_words.pop_front();
				compare_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
				compare_field("out_tag", 32'(want.out_tag), 32'(got.out_tag));
				compare_field("out_dir", 32'(want.out_dir), 32'(got.out_dir));
				compare_field("out_dc_mode", 32'(want.out_dc_mode), 32'(got.out_dc_mode));
				compare_field("out_cs_id", 32'(want.out_cs_id), 32'(got.out_cs_id));
				compare_field("out_tx_addr", want.out_tx_addr, got.out_tx_addr);
				compare_field("out_rx_addr", want.out_rx_addr, got.out_rx_addr);
				compare_field("out_length", 32'(want.out_length), 32'(got.out_length));
				compare_field("out_ctrl_one", want.out_ctrl_one, got.out_ctrl_one);
				compare_field("out_ctrl_two", want.out_ctrl_two, got.out_ctrl_two);
				compare_field("idle", 32'(want.idle), 32'(got.idle));
				compare_field("last", 32'(want.last), 32'(got.last));
				kind_tally[int'(want.event_kind)]++;
			end
			words_checked++;
		end
	end

	// result side stalls at random
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
		end
	end

	// run limit
	initial begin
		while (cycle_count < CycleLimit) @(posedge clk);
		$display("timeout after %0d cycles, %0d words still expected",
		         cycle_count, expected_words.size());
		$display("spi_transaction_queue_sequencer_tb: FAIL");
		$finish;
	end

	// stimulus
	initial begin
		int         next_fill;
		int         pick;
		int         directed_count;
		logic [2:0] op;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		arst_n = 1'b0;
		foreach (kind_tally[i]) kind_tally[i] = 0;

		// nothing in flight: bus events, cancel and the reserved code are ignored
		add_row(stq_pkg::REQ_HALF, 16'h0000, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b1, 1'b0, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_COMPLETE, 16'h0001, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b1, 1'b0, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_BUS_ERROR, 16'h0002, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b0, 1'b0, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_START_REFUSED, 16'h0003, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0,
		        32'h0, 32'h0, 1'b0, 1'b0, stq_pkg::EV_OK);
		add_row(ReqReserved, 16'hffff, 1'b1, 2'd3, 4'hf, 32'hffffffff, 32'hffffffff, 16'hffff,
		        32'hffffffff, 32'hffffffff, 1'b1, 1'b0, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_CANCEL, 16'h0004, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b0, 1'b0, stq_pkg::EV_OK);
		// submit checks: no select, no transmit buffer, zero length, no receive buffer
		add_row(stq_pkg::REQ_SUBMIT, 16'h0101, 1'b0, 2'd1, 4'h0, 32'h100, 32'h0, 16'h10, 32'h0,
		        32'h0, 1'b0, 1'b1, stq_pkg::EV_PARAM);
		add_row(stq_pkg::REQ_SUBMIT, 16'h0102, 1'b0, 2'd1, 4'h3, 32'h0, 32'h200, 16'h10, 32'h0,
		        32'h0, 1'b0, 1'b1, stq_pkg::EV_PARAM);
		add_row(stq_pkg::REQ_SUBMIT, 16'h0103, 1'b0, 2'd2, 4'h3, 32'h100, 32'h200, 16'h0,
		        32'h0, 32'h0, 1'b0, 1'b1, stq_pkg::EV_PARAM);
		add_row(stq_pkg::REQ_SUBMIT, 16'h0104, 1'b1, 2'd2, 4'h3, 32'h100, 32'h0, 16'h10, 32'h0,
		        32'h0, 1'b0, 1'b1, stq_pkg::EV_PARAM);
		// marker on a quiet bus retires at once
		add_row(stq_pkg::REQ_MARKER, 16'hffff, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b0, 1'b1, stq_pkg::EV_OK);
		// all-ones transfer with the illegal dc level, then its half event
		add_row(stq_pkg::REQ_SUBMIT, 16'hffff, 1'b1, 2'd3, 4'hf, 32'hffffffff, 32'hffffffff,
		        16'hffff, 32'hffffffff, 32'hffffffff, 1'b1, 1'b1, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_HALF, 16'h0000, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b0, 1'b1, stq_pkg::EV_HALF);
		// queue marker, smallest transfer, marker behind the busy bus
		add_row(stq_pkg::REQ_MARKER, 16'h0200, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b0, 1'b1, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_SUBMIT, 16'h0000, 1'b0, 2'd0, 4'h1, 32'h1, 32'h0, 16'h1, 32'h0,
		        32'h0, 1'b0, 1'b1, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_MARKER, 16'h0201, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b0, 1'b0, stq_pkg::EV_OK);
		// completion in time, then timed out, then a bus error on a new transfer
		add_row(stq_pkg::REQ_COMPLETE, 16'h0000, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b1, 1'b1, stq_pkg::EV_DONE);
		add_row(stq_pkg::REQ_COMPLETE, 16'h0000, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b0, 1'b1, stq_pkg::EV_ERROR);
		add_row(stq_pkg::REQ_SUBMIT, 16'h0300, 1'b1, 2'd2, 4'h5, 32'ha5a50000, 32'h5a5a0000,
		        16'h0040, 32'h12345678, 32'h00000708, 1'b0, 1'b0, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_BUS_ERROR, 16'h0000, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b0, 1'b1, stq_pkg::EV_ERROR);
		// cancel keeps the transfer in flight and drops what waits behind it
		add_row(stq_pkg::REQ_SUBMIT, 16'h0301, 1'b0, 2'd1, 4'h9, 32'h00001000, 32'h0, 16'h0008,
		        32'h0000ff00, 32'h0000000f, 1'b0, 1'b0, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_SUBMIT, 16'h0302, 1'b1, 2'd2, 4'ha, 32'h00002000, 32'h00003000,
		        16'h0100, 32'h0, 32'h7, 1'b0, 1'b0, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_MARKER, 16'h0303, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b0, 1'b0, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_CANCEL, 16'h0000, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0, 32'h0,
		        32'h0, 1'b0, 1'b0, stq_pkg::EV_OK);
		add_row(stq_pkg::REQ_START_REFUSED, 16'h0000, 1'b0, 2'd0, 4'h0, 32'h0, 32'h0, 16'h0,
		        32'h0, 32'h0, 1'b0, 1'b1, stq_pkg::EV_ERROR);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) send_request(rows[i].word, rows[i].given, rows[i].kind);
		directed_count = words_sent;

		// random part: fill bursts to reach a full ring, weighted traffic in between
		next_fill = words_sent;
		while (words_sent < ItemTarget) begin
			steady = words_sent >= 200 && words_sent < 300;
			if (words_sent >= next_fill) begin
				for (int k = 0; k < 18; k++)
					send_request(random_request(($urandom_range(3) == 0) ?
					                            stq_pkg::REQ_MARKER : stq_pkg::REQ_SUBMIT,
					                            1'b1), 1'b0, stq_pkg::EV_OK);
				if ($urandom_range(1) == 0)
					send_request(random_request(stq_pkg::REQ_CANCEL, 1'b1), 1'b0,
					             stq_pkg::EV_OK);
				next_fill = words_sent + 50 + $urandom_range(40);
			end else begin
				pick = $urandom_range(99);
				if (pick < 35) op = stq_pkg::REQ_SUBMIT;
				else if (pick < 50) op = stq_pkg::REQ_MARKER;
				else if (pick < 58) op = stq_pkg::REQ_HALF;
				else if (pick < 78) op = stq_pkg::REQ_COMPLETE;
				else if (pick < 84) op = stq_pkg::REQ_BUS_ERROR;
				else if (pick < 90) op = stq_pkg::REQ_START_REFUSED;
				else if (pick < 94) op = stq_pkg::REQ_CANCEL;
				else if (pick < 96) op = ReqReserved;
				else op = 3'($urandom);
				send_request(random_request(op, pick < 96), 1'b0, stq_pkg::EV_OK);
			end
		end
		steady = 1'b0;
		req_ch.valid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d request words (%0d from the table), %0d result words checked",
		         words_sent, directed_count, words_checked);
		$display("  starts %0d, markers %0d, done %0d, errors %0d, full %0d, param %0d",
		         kind_tally[int'(stq_pkg::EV_START)], kind_tally[int'(stq_pkg::EV_MARKER)],
		         kind_tally[int'(stq_pkg::EV_DONE)], kind_tally[int'(stq_pkg::EV_ERROR)],
		         kind_tally[int'(stq_pkg::EV_FULL)], kind_tally[int'(stq_pkg::EV_PARAM)]);
		if (failures == 0 && expected_words.size() == 0) begin
			$display("spi_transaction_queue_sequencer_tb: PASS");
		end else begin
			$display("spi_transaction_queue_sequencer_tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/stq_pkg.sv
design/stq_req_if.sv
design/stq_rsp_if.sv
design/stq_entry_ram.sv
design/spi_transaction_queue_sequencer.sv
tb/spi_transaction_queue_sequencer_tb.sv
